// ===== rtl/core/mrh_pkg.sv =====
package mrh_pkg;

  // Request header as stored for the response: transaction ID, protocol ID,
  // length, unit ID, function code, start address and quantity.
  localparam int HEADER_LEN = 12;
  localparam int HDR_AW     = $clog2(HEADER_LEN);

  // Default size of the holding register store.
  localparam int REG_COUNT_DEFAULT = 16;

  // Largest quantity a request may ever ask for.
  localparam int QTY_CAP = 16;

  // Configuration register indexes.
  localparam int CFG_IW = 1;
  localparam logic [CFG_IW-1:0] CFG_ADDRESS_LIMIT = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_MAX_QUANTITY  = 1'b1;
  localparam logic [4:0]        CFG_RESET_VALUE   = 5'd10;

  // Protocol constants.
  localparam logic [7:0] FC_READ_HOLDING = 8'h03;
  localparam logic [7:0] FC_MAX          = 8'h17;
  localparam logic [7:0] EXC_FLAG        = 8'h80;
  localparam logic [7:0] EXC_PDU_LEN     = 8'h03;
  localparam logic [7:0] PDU_FIXED_LEN   = 8'h03;
  localparam logic [7:0] FRAME_CNT_MAX   = 8'hFF;

  // Exception codes.
  localparam logic [7:0] EXC_NONE          = 8'h00;
  localparam logic [7:0] EXC_ILLEGAL_FUNC  = 8'h01;
  localparam logic [7:0] EXC_ILLEGAL_ADDR  = 8'h02;
  localparam logic [7:0] EXC_ILLEGAL_VALUE = 8'h03;

  // Header byte positions, shared by capture and response.
  localparam logic [HDR_AW-1:0] POS_TID_HI   = 4'd0;
  localparam logic [HDR_AW-1:0] POS_TID_LO   = 4'd1;
  localparam logic [HDR_AW-1:0] POS_PID_HI   = 4'd2;
  localparam logic [HDR_AW-1:0] POS_PID_LO   = 4'd3;
  localparam logic [HDR_AW-1:0] POS_LEN_HI   = 4'd4;
  localparam logic [HDR_AW-1:0] POS_LEN_LO   = 4'd5;
  localparam logic [HDR_AW-1:0] POS_UID      = 4'd6;
  localparam logic [HDR_AW-1:0] POS_FC       = 4'd7;
  localparam logic [HDR_AW-1:0] POS_START_HI = 4'd8;
  localparam logic [HDR_AW-1:0] POS_START_LO = 4'd9;
  localparam logic [HDR_AW-1:0] POS_QTY_HI   = 4'd10;
  localparam logic [HDR_AW-1:0] POS_QTY_LO   = 4'd11;
  // In the response the byte count (or exception code) sits where the
  // request carried the start address.
  localparam logic [HDR_AW-1:0] POS_BYTE_CNT = 4'd8;

  typedef struct packed {
    logic              we;
    logic [HDR_AW-1:0] addr;
    logic [7:0]        data;
  } hdr_wr_t;

  typedef struct packed {
    logic              re;
    logic [HDR_AW-1:0] addr;
  } hdr_rd_t;

endpackage

// ===== rtl/core/modbus_read_holding_responder_top.sv =====
// After the final request byte, a check state precedes the first reply item.
// Throughput: one request byte or register write per cycle while idle; a frame
// then holds intake until its reply is out: 1 (reject), 9 (exception) or 9 + 2N.
// The reply streams one item per cycle while out_ready stays high.
// Reset: synchronous, active high; clears control state, configuration (both 10)
// and the store's valid bits, so every holding register reads zero after reset.
module modbus_read_holding_responder_top #(
  parameter int REG_COUNT = mrh_pkg::REG_COUNT_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  // Request side: frame bytes (mode 0) and register writes (mode 1).
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       mode,
  input  logic [7:0]                 frame_byte,
  input  logic                       frame_end,
  input  logic [3:0]                 reg_index,
  input  logic [15:0]                reg_value,
  // Reply side: one response byte per item.
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 reply_byte,
  output logic                       reply_end,
  output logic                       frame_rejected,
  // Configuration write port.
  input  logic                       cfg_we,
  input  logic [mrh_pkg::CFG_IW-1:0] cfg_index,
  input  logic [4:0]                 cfg_data
);
  import mrh_pkg::*;

  localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  // The block has two memories. The header memory keeps the first twelve
  // bytes of the request so that the transaction and unit IDs can be echoed
  // back. The register store holds the holding registers; its read data is
  // registered, so the controller issues each read ahead of the item that
  // carries it. The store is only written while the controller is
  // idle and only read while a response is in flight, so the input handshake
  // itself acts as the interlock between the two.

  logic [4:0]    address_limit;
  logic [4:0]    max_quantity;
  hdr_wr_t       hdr_wr;
  hdr_rd_t       hdr_rd;
  logic [7:0]    hdr_rdata;
  logic          reg_we;
  logic [AW-1:0] reg_waddr;
  logic [15:0]   reg_wdata;
  logic          reg_re;
  logic [AW-1:0] reg_raddr;
  logic [15:0]   reg_rdata;

  // Configuration registers. They are sampled by the header check, which
  // runs only after a complete frame has arrived.
  always_ff @(posedge clk) begin
    if (rst) begin
      address_limit <= CFG_RESET_VALUE;
      max_quantity  <= CFG_RESET_VALUE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ADDRESS_LIMIT: address_limit <= cfg_data;
        CFG_MAX_QUANTITY:  max_quantity  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The controller counts request bytes, extracts the header fields, checks
  // the frame in the cycle after its final byte, then walks the response: a
  // lone reject item, or nine header bytes plus two bytes per register if normal.
  mrh_ctrl #(
    .REG_COUNT(REG_COUNT),
    .AW       (AW)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .frame_byte    (frame_byte),
    .frame_end     (frame_end),
    .reg_index     (reg_index),
    .reg_value     (reg_value),
    .address_limit (address_limit),
    .max_quantity  (max_quantity),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .reply_byte    (reply_byte),
    .reply_end     (reply_end),
    .frame_rejected(frame_rejected),
    .hdr_wr        (hdr_wr),
    .hdr_rd        (hdr_rd),
    .hdr_rdata     (hdr_rdata),
    .reg_we        (reg_we),
    .reg_waddr     (reg_waddr),
    .reg_wdata     (reg_wdata),
    .reg_re        (reg_re),
    .reg_raddr     (reg_raddr),
    .reg_rdata     (reg_rdata)
  );

  mrh_hdr_mem u_hdr_mem (
    .clk  (clk),
    .wr   (hdr_wr),
    .rd   (hdr_rd),
    .rdata(hdr_rdata)
  );

  mrh_reg_store #(
    .REG_COUNT(REG_COUNT),
    .AW       (AW)
  ) u_reg_store (
    .clk  (clk),
    .rst  (rst),
    .we   (reg_we),
    .waddr(reg_waddr),
    .wdata(reg_wdata),
    .re   (reg_re),
    .raddr(reg_raddr),
    .rdata(reg_rdata)
  );

endmodule

// ===== rtl/core/mrh_hdr_mem.sv =====
module mrh_hdr_mem (
  input  logic             clk,
  input  mrh_pkg::hdr_wr_t wr,
  input  mrh_pkg::hdr_rd_t rd,
  output logic [7:0]       rdata
);
  import mrh_pkg::*;

  logic [7:0] mem [HEADER_LEN];

  // Entries are written as request bytes arrive; contents are undefined
  // until the first frame has filled them.
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.re) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule

// ===== rtl/core/mrh_reg_store.sv =====
module mrh_reg_store #(
  parameter int REG_COUNT = mrh_pkg::REG_COUNT_DEFAULT,
  parameter int AW        = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);
  import mrh_pkg::*;

  logic [15:0]          mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld;
  logic [15:0]          mem_q;
  logic                 vld_q;

  // One valid bit per entry stands in for clearing the store at reset:
  // an entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      mem_q <= mem[raddr];
      vld_q <= vld[raddr];
    end
  end

  assign rdata = vld_q ? mem_q : 16'h0000;

endmodule

// ===== rtl/core/mrh_ctrl.sv =====
module mrh_ctrl #(
  parameter int REG_COUNT = mrh_pkg::REG_COUNT_DEFAULT,
  parameter int AW        = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             mode,
  input  logic [7:0]       frame_byte,
  input  logic             frame_end,
  input  logic [3:0]       reg_index,
  input  logic [15:0]      reg_value,
  input  logic [4:0]       address_limit,
  input  logic [4:0]       max_quantity,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       reply_byte,
  output logic             reply_end,
  output logic             frame_rejected,
  output mrh_pkg::hdr_wr_t hdr_wr,
  output mrh_pkg::hdr_rd_t hdr_rd,
  input  logic [7:0]       hdr_rdata,
  output logic             reg_we,
  output logic [AW-1:0]    reg_waddr,
  output logic [15:0]      reg_wdata,
  output logic             reg_re,
  output logic [AW-1:0]    reg_raddr,
  input  logic [15:0]      reg_rdata
);
  import mrh_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_REJ   = 6'b000100,
    S_HEAD  = 6'b001000,
    S_HI    = 6'b010000,
    S_LO    = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [7:0]  bytes_received;
  logic [7:0]  cnt_sat;
  logic [7:0]  frame_len;
  logic        acc_byte, acc_wr;
  logic        slot_free;

  // Header fields picked off as bytes arrive.
  logic        pid_nz;
  logic [15:0] lenf;
  logic [7:0]  fc;
  logic [15:0] start_addr;
  logic [15:0] qty;

  // Results of the header check.
  logic        chk_reject;
  logic [7:0]  chk_code;
  logic [4:0]  qlim, alim;
  logic        exc;
  logic [7:0]  exc_code;
  logic [4:0]  qty_n;

  // Response sequencing.
  logic [HDR_AW-1:0] pos;
  logic [AW-1:0]     reg_addr;
  logic [4:0]        wcnt;
  logic              last_word;
  logic [7:0]        len_lo;
  logic [7:0]        head_byte;
  logic              emit, emit_end, emit_rej;
  logic [7:0]        emit_byte;

  assign in_ready  = (state == S_IDLE);
  assign acc_byte  = in_valid && in_ready && !mode;
  assign acc_wr    = in_valid && in_ready && mode;
  assign slot_free = !out_valid || out_ready;
  assign cnt_sat   = (bytes_received == FRAME_CNT_MAX) ? FRAME_CNT_MAX
                                                       : bytes_received + 8'd1;

  assign hdr_wr.we   = acc_byte && (bytes_received < 8'(HEADER_LEN));
  assign hdr_wr.addr = bytes_received[HDR_AW-1:0];
  assign hdr_wr.data = frame_byte;

  // Indexes beyond the store are dropped.
  assign reg_we    = acc_wr && (32'(reg_index) < REG_COUNT);
  assign reg_waddr = AW'(reg_index);
  assign reg_wdata = reg_value;

  // Header check, evaluated in the cycle after the final byte.
  assign qlim = (max_quantity < 5'(QTY_CAP)) ? max_quantity : 5'(QTY_CAP);
  assign alim = (32'(address_limit) < REG_COUNT) ? address_limit : 5'(REG_COUNT);

  assign chk_reject = (frame_len < 8'(HEADER_LEN)) || (frame_len == FRAME_CNT_MAX) ||
                      pid_nz || (lenf != (16'(frame_len) - 16'd6)) || (fc > FC_MAX);

  always_comb begin
    if (fc != FC_READ_HOLDING) begin
      chk_code = EXC_ILLEGAL_FUNC;
    end else if ((qty == 16'd0) || (qty > 16'(qlim))) begin
      chk_code = EXC_ILLEGAL_VALUE;
    end else if ((17'(start_addr) + 17'(qty)) > 17'(alim)) begin
      chk_code = EXC_ILLEGAL_ADDR;
    end else begin
      chk_code = EXC_NONE;
    end
  end

  assign len_lo    = PDU_FIXED_LEN + {2'b00, qty_n, 1'b0};
  assign last_word = ((wcnt + 5'd1) == qty_n);

  always_comb begin
    case (pos)
      POS_LEN_HI:   head_byte = 8'h00;
      POS_LEN_LO:   head_byte = exc ? EXC_PDU_LEN : len_lo;
      POS_FC:       head_byte = exc ? (fc | EXC_FLAG) : fc;
      POS_BYTE_CNT: head_byte = exc ? exc_code : {2'b00, qty_n, 1'b0};
      default:      head_byte = hdr_rdata;
    endcase
  end

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    emit_byte  = 8'h00;
    emit_end   = 1'b0;
    emit_rej   = 1'b0;
    hdr_rd.re   = 1'b0;
    hdr_rd.addr = pos + 1'b1;
    reg_re     = 1'b0;
    reg_raddr  = reg_addr;
    case (state)
      S_IDLE: begin
        if (acc_byte && frame_end) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        hdr_rd.re   = 1'b1;
        hdr_rd.addr = POS_TID_HI;
        state_next  = chk_reject ? S_REJ : S_HEAD;
      end
      S_REJ: begin
        if (slot_free) begin
          emit       = 1'b1;
          emit_end   = 1'b1;
          emit_rej   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_HEAD: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_byte = head_byte;
          hdr_rd.re = 1'b1;
          if (pos == POS_BYTE_CNT) begin
            emit_end   = exc;
            reg_re     = !exc;
            state_next = exc ? S_IDLE : S_HI;
          end
        end
      end
      S_HI: begin
        if (slot_free) begin
          emit       = 1'b1;
          emit_byte  = reg_rdata[15:8];
          state_next = S_LO;
        end
      end
      S_LO: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_byte = reg_rdata[7:0];
          emit_end  = last_word;
          if (last_word) begin
            state_next = S_IDLE;
          end else begin
            reg_re     = 1'b1;
            reg_raddr  = reg_addr + 1'b1;
            state_next = S_HI;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      bytes_received <= 8'd0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (acc_byte) begin
        bytes_received <= frame_end ? 8'd0 : cnt_sat;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_byte) begin
      if (frame_end) begin
        frame_len <= cnt_sat;
      end
      if (bytes_received < 8'(HEADER_LEN)) begin
        case (bytes_received[HDR_AW-1:0])
          POS_PID_HI:   pid_nz           <= (frame_byte != 8'h00);
          POS_PID_LO:   pid_nz           <= pid_nz || (frame_byte != 8'h00);
          POS_LEN_HI:   lenf[15:8]       <= frame_byte;
          POS_LEN_LO:   lenf[7:0]        <= frame_byte;
          POS_FC:       fc               <= frame_byte;
          POS_START_HI: start_addr[15:8] <= frame_byte;
          POS_START_LO: start_addr[7:0]  <= frame_byte;
          POS_QTY_HI:   qty[15:8]        <= frame_byte;
          POS_QTY_LO:   qty[7:0]         <= frame_byte;
          default: begin
          end
        endcase
      end
    end

    if (state == S_CHECK) begin
      exc      <= (chk_code != EXC_NONE);
      exc_code <= chk_code;
      qty_n    <= qty[4:0];
      reg_addr <= AW'(start_addr);
      pos      <= POS_TID_HI;
      wcnt     <= 5'd0;
    end
    if ((state == S_HEAD) && emit) begin
      pos <= pos + 1'b1;
    end
    if ((state == S_LO) && emit) begin
      reg_addr <= reg_addr + 1'b1;
      wcnt     <= wcnt + 5'd1;
    end

    if (emit) begin
      reply_byte     <= emit_byte;
      reply_end      <= emit_end;
      frame_rejected <= emit_rej;
    end
  end

endmodule

// ===== rtl/core/mrh_checker.sv =====
module mrh_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       mode,
  input logic       frame_end,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] reply_byte,
  input logic       reply_end,
  input logic       frame_rejected
);
  import mrh_pkg::*;

  // A reject item is always a lone, final item with a zero byte.
  a_reject_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_rejected |-> reply_end && (reply_byte == 8'h00))
    else $error("reject item is not a lone final zero byte");

  // The final byte of a frame stops intake while the frame is answered.
  a_frame_end_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !mode && frame_end |=> !in_ready)
    else $error("input still taken after the final byte of a frame");

  // A register write never stalls the input.
  a_write_no_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && mode |=> in_ready)
    else $error("register write stalled the input");

  // A stalled reply item holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(reply_byte) &&
                                $stable(reply_end) && $stable(frame_rejected))
    else $error("reply item changed while stalled");

endmodule

bind modbus_read_holding_responder_top mrh_checker u_mrh_checker (.*);
